### rtl/assert_macros.svh
// Assertion macros used by the checker of the deque.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert that a condition in one cycle implies another in the next cycle.
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/wsd_pkg.sv
// Types and constants of the work-stealing deque.
`timescale 1ns / 1ps

package wsd_pkg;

  // Operation selector carried on the input word
  localparam int unsigned KIND_W = 2;
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_TAKE = 2'd2
  } kind_e;

  // Fixed field widths of the stream words
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned SIZE_RESET_CAP = 10;
  localparam logic        REG_SIZE_LOG2  = 1'b0;

endpackage

### rtl/wsd_ring.sv
// Single-port synchronous ring memory holding the task words.
`timescale 1ns / 1ps

module wsd_ring #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned WORD_W = 32
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [WORD_W-1:0] ring_mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write on a push, register the read word otherwise
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        ring_mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= ring_mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/work_stealing_deque.sv
// Top level of the work-stealing deque: pointer logic, ring memory and ports.
`timescale 1ns / 1ps

// Work-stealing deque of task words held in a ring of 2^size_log2 slots (one
// slot always stays free). Each input word carries a push, pop (bottom end) or
// take (top end); each gives exactly one result word with ok, the removed word
// and the entry count afterwards. The block takes one item per clock cycle:
// the top and bottom pointers live in flip-flops and each item makes at most
// one access to the single-port ring memory, so results appear in the cycle after
// acceptance. Input is held off only while a finished result waits on a
// stalled output. There is no clearing pass after reset: slots are only read
// after a push wrote them. Writing size_log2 (clamped to 1..MAX_LOG2) empties
// the deque and must be done while the block is idle.
module work_stealing_deque
  import wsd_pkg::*;
#(
  parameter int unsigned MAX_LOG2   = 10,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [31:0] push_value
  input  logic [KIND_W-1:0]      s_axis_tuser_i,   // [1:0] kind
  // Result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] pop_value, [41:32] used_count
  output logic [0:0]             m_axis_tuser_o,   // [0] ok
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned IDX_W  = MAX_LOG2 + 1;
  localparam int unsigned ADDR_W = MAX_LOG2;
  localparam int unsigned WEXT_W = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;
  localparam int unsigned CEXT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int unsigned SIZE_RST_I = (MAX_LOG2 < SIZE_RESET_CAP) ? MAX_LOG2 : SIZE_RESET_CAP;
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(SIZE_RST_I);
  localparam logic [SIZE_W:0]   SIZE_MAX = (SIZE_W + 1)'(MAX_LOG2);
  localparam logic [IDX_W-1:0]  IDX_ONE  = IDX_W'(1);

  // Pointer and configuration state
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  top_q, top_d;
  logic [IDX_W-1:0]  bot_q, bot_d;

  // Result register
  logic               valid_q;
  logic               ok_q;
  logic               rd_q;
  logic [COUNT_W-1:0] cnt_q;

  logic               accept;
  logic               cfg_wr;
  logic [SIZE_W-1:0]  size_wr;
  logic [IDX_W-1:0]   mask;
  logic [IDX_W-1:0]   count;
  logic [IDX_W-1:0]   count_nxt;
  logic [CEXT_W-1:0]  count_ext;
  kind_e              kind;
  logic               op_ok;
  logic               op_rd;
  logic               mem_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_idx;
  logic [ADDR_W-1:0]  mem_addr;
  logic [WEXT_W-1:0]  push_ext;
  logic [WEXT_W-1:0]  pop_ext;
  logic [WORD_WIDTH-1:0] mem_rdata;
  logic [DATA_W-1:0]  pop_value;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = ~valid_q | m_axis_tready_i;

  // Configuration decode and clamp
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SIZE_LOG2);

  always_comb begin
    priority if (pwdata[SIZE_W-1:0] == '0) begin
      size_wr = SIZE_W'(1);
    end else if ({1'b0, pwdata[SIZE_W-1:0]} > SIZE_MAX) begin
      size_wr = SIZE_MAX[SIZE_W-1:0];
    end else begin
      size_wr = pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SIZE_LOG2) ? APB_DATA_W'(size_q) : '0;

  // Ring mask and occupancy
  assign mask  = (IDX_ONE << size_q) - IDX_ONE;
  assign count = bot_q - top_q;
  assign kind  = kind_e'(s_axis_tuser_i);

  // Decide the operation, the pointer moves and the memory access
  always_comb begin
    op_ok   = 1'b0;
    op_rd   = 1'b0;
    mem_we  = 1'b0;
    mem_idx = bot_q;
    top_d   = top_q;
    bot_d   = bot_q;
    unique case (kind)
      KIND_PUSH: begin
        if (count < mask) begin
          op_ok  = 1'b1;
          mem_we = 1'b1;
          bot_d  = bot_q + IDX_ONE;
        end
      end
      KIND_POP: begin
        if (count != '0) begin
          op_ok   = 1'b1;
          op_rd   = 1'b1;
          mem_idx = bot_q - IDX_ONE;
          // Last entry: advance top past it, leave bottom
          if (count == IDX_ONE) begin
            top_d = top_q + IDX_ONE;
          end else begin
            bot_d = bot_q - IDX_ONE;
          end
        end
      end
      KIND_TAKE: begin
        if (count != '0) begin
          op_ok   = 1'b1;
          op_rd   = 1'b1;
          mem_idx = top_q;
          top_d   = top_q + IDX_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_nxt = bot_d - top_d;
  assign count_ext = CEXT_W'(count_nxt);
  assign mem_en    = accept & op_ok;
  assign mem_addr  = mem_idx[ADDR_W-1:0] & mask[ADDR_W-1:0];
  assign push_ext  = WEXT_W'(s_axis_tdata_i);

  wsd_ring #(
    .ADDR_W (ADDR_W),
    .WORD_W (WORD_WIDTH)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (push_ext[WORD_WIDTH-1:0]),
    .rdata_o (mem_rdata)
  );

  // Hold pointers and size; a size write empties the deque
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
      top_q  <= '0;
      bot_q  <= '0;
    end else if (cfg_wr) begin
      size_q <= size_wr;
      top_q  <= '0;
      bot_q  <= '0;
    end else if (accept) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

  // Advance the result word, hold it while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q  <= op_ok;
      rd_q  <= op_rd;
      cnt_q <= count_ext[COUNT_W-1:0];
    end
  end

  // Drive the result word
  assign pop_ext   = WEXT_W'(mem_rdata);
  assign pop_value = rd_q ? pop_ext[DATA_W-1:0] : '0;

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = ok_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({cnt_q, pop_value});

endmodule

### rtl/wsd_checker.sv
// Port-level checker of the work-stealing deque and its bind.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module wsd_checker
  import wsd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]             m_axis_tuser_o
);

  // A failed operation returns a zero word
  `WSD_ASSERT(a_fail_zero, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[DATA_W-1:0] == '0), "failed result carries a nonzero word")

  // Input is held off only behind a stalled result
  `WSD_ASSERT(a_ready_stall, clk_i, rst_ni, !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i), "input held off without a stalled result")

  // Every accepted word shows a result in the next cycle
  `WSD_ASSERT_NEXT(a_result_next, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o, "accepted word gave no result")

  // A stalled result holds
  `WSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (.*);
